/* rtl/upi_pkg.sv */
// shared types and constants of the unicycle pose integrator
// no dependencies; used by the controller, datapath, sine rom and top level
package upi_pkg;

  localparam int SPEED_W = 16;
  localparam int RATE_W  = 16;
  localparam int TIME_W  = 20;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int TRIG_W  = 16;

  // stream payload widths, padded to whole bytes
  localparam int IN_W  = 56;
  localparam int OUT_W = 112;

  // quarter turn in heading units, full-scale sine magnitude
  localparam logic [HEAD_W-1:0] QUARTER  = 16'h4000;
  localparam logic [TRIG_W-1:0] SINE_MAX = 16'd32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOOK,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;   // capture request fields
    logic rom_load;  // capture both sine rom read ports
    logic rom_half;  // rom addresses from half of the new heading
    logic calc;      // register sin/cos of old heading, distance and turn
    logic prod;      // register x and y increments
    logic commit;    // update pose and quaternion output
  } upi_cmd_t;

endpackage

/* rtl/upi_sine_rom.sv */
// quarter-wave sine table, two registered read ports
// depends on upi_pkg for the full-scale constant
module upi_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr_a,
  input  logic [$clog2(DEPTH)-1:0] addr_b,
  output logic [15:0]              data_a,
  output logic [15:0]              data_b
);
  import upi_pkg::*;

  localparam real PI_R = 3.14159265358979323846;
  // angle between neighboring entries
  localparam real ANG_STEP = PI_R / (2.0 * real'(DEPTH));

  typedef logic [15:0] rom_t [DEPTH];

  // entry i = round(32767 * sin(i * pi / (2 * DEPTH)))
  function automatic rom_t build_rom();
    rom_t t;
    real  ang;
    real  v;
    int   q;
    for (int i = 0; i < DEPTH; i++) begin
      ang = ANG_STEP * real'(i);
      v = 32767.0 * $sin(ang) + 0.5;
      q = $rtoi(v);
      if (q > int'(SINE_MAX)) q = int'(SINE_MAX);
      t[i] = 16'(q);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule

/* rtl/upi_datapath.sv */
// pose datapath: multiplies, sine lookups and pose accumulators
// depends on upi_pkg and upi_sine_rom
module upi_datapath #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  upi_pkg::upi_cmd_t          cmd,
  input  logic [upi_pkg::IN_W-1:0]   in_data,
  output logic [upi_pkg::OUT_W-1:0]  out_data
);
  import upi_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = 14 + AW;

  typedef struct packed {
    logic          neg;
    logic          full;
    logic [AW-1:0] addr;
  } look_t;

  // quadrant folding of a 16-bit angle onto the quarter-wave table
  function automatic look_t sine_look(input logic [15:0] ang);
    logic [PW-1:0] prod;
    logic [AW-1:0] idx;
    logic [AW:0]   mirror;
    look_t         r;
    prod = PW'(ang[13:0]) * PW'(SINE_TABLE_DEPTH);
    idx = prod[PW-1:14];
    mirror = (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, idx};
    r.neg = ang[15];
    r.full = ang[14] && (idx == '0);
    r.addr = ang[14] ? mirror[AW-1:0] : idx;
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sine_val(input logic [15:0] mag,
                                                        input logic neg,
                                                        input logic full);
    logic [TRIG_W-1:0] m;
    m = full ? SINE_MAX : mag;
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // request fields
  logic signed [SPEED_W-1:0] speed;
  logic signed [RATE_W-1:0]  rate;
  logic [TIME_W-1:0]         etime;

  // pose state
  logic [POS_W-1:0]  x;
  logic [POS_W-1:0]  y;
  logic [HEAD_W-1:0] heading;

  // intermediate registers
  logic signed [TRIG_W-1:0] sin_v;
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [28:0]       travel;
  logic [HEAD_W-1:0]        dh;
  logic signed [29:0]       dx;
  logic signed [29:0]       dy;
  logic signed [TRIG_W-1:0] qz;
  logic signed [TRIG_W-1:0] qw;

  logic signed [36:0] vt_prod;
  logic signed [36:0] wt_prod;
  logic signed [44:0] dx_prod;
  logic signed [44:0] dy_prod;
  logic [HEAD_W-1:0]  hd_sum;
  logic [HEAD_W-1:0]  ang_a;
  logic [HEAD_W-1:0]  ang_b;
  look_t              look_a;
  look_t              look_b;
  look_t              fix_a;
  look_t              fix_b;
  logic [15:0]        rom_a;
  logic [15:0]        rom_b;

  assign vt_prod = speed * $signed({1'b0, etime});
  assign wt_prod = rate * $signed({1'b0, etime});
  assign dx_prod = travel * cos_v;
  assign dy_prod = travel * sin_v;

  // new heading, and rom angles: old heading, or half of the new one
  assign hd_sum = heading + dh;
  assign ang_a  = cmd.rom_half ? {1'b0, hd_sum[HEAD_W-1:1]} : heading;
  assign ang_b  = ang_a + QUARTER;
  assign look_a = sine_look(ang_a);
  assign look_b = sine_look(ang_b);

  upi_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk(clk),
    .en(cmd.rom_load),
    .addr_a(look_a.addr),
    .addr_b(look_b.addr),
    .data_a(rom_a),
    .data_b(rom_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      speed <= $signed(in_data[15:0]);
      rate  <= $signed(in_data[31:16]);
      etime <= in_data[51:32];
    end
    if (cmd.rom_load) begin
      fix_a <= look_a;
      fix_b <= look_b;
    end
    if (cmd.calc) begin
      sin_v  <= sine_val(rom_a, fix_a.neg, fix_a.full);
      cos_v  <= sine_val(rom_b, fix_b.neg, fix_b.full);
      travel <= vt_prod[36:8];
      dh     <= wt_prod[27:12];
    end
    if (cmd.prod) begin
      dx <= dx_prod[44:15];
      dy <= dy_prod[44:15];
    end
    if (cmd.commit) begin
      qz <= sine_val(rom_a, fix_a.neg, fix_a.full);
      qw <= sine_val(rom_b, fix_b.neg, fix_b.full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x       <= '0;
      y       <= '0;
      heading <= '0;
    end else if (cmd.commit) begin
      x       <= x + POS_W'(dx);
      y       <= y + POS_W'(dy);
      heading <= hd_sum;
    end
  end

  // pose registers change only at reset or commit, so they double as the result
  assign out_data = {qw, qz, heading, y, x};

endmodule

/* rtl/upi_ctrl.sv */
// sequencer for one request: accept, multiply, lookup, commit
// depends on upi_pkg for the state and command types
module upi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output upi_pkg::upi_cmd_t cmd
);
  import upi_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // keep sin/cos of the current heading in the rom registers
        cmd.rom_load = 1'b1;
        cmd.load_in  = in_valid;
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.calc   = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.prod     = 1'b1;
        cmd.rom_load = 1'b1;
        cmd.rom_half = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL))
    else $error("accepted request did not start the multiply step");

  a_mul_to_look: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_LOOK))
    else $error("multiply step not followed by lookup");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |-> !cmd.commit)
    else $error("result overwritten before it was taken");
`endif

endmodule

/* rtl/unicycle_pose_integrator_core.sv */
// channel  dir  tdata fields, lowest bit up
// s_*      in   linear_speed[15:0] angular_rate[31:16] elapsed_time[51:32] zero[55:52]
// m_*      out  pos_x[31:0] pos_y[63:32] heading[79:64] quat_z[95:80] quat_w[111:96]
//
// each request steps through accept, multiply, lookup, commit; the chain of two
// registered multiplies and the second registered sine rom read sets those steps
// reset clears pose and heading; the sine table is a constant rom
// the result sits in the pose registers; a new request is accepted while it waits
// commit stalls until m_tready frees the output
// depends on upi_pkg, upi_ctrl, upi_datapath, upi_sine_rom
module unicycle_pose_integrator_core #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // linear_speed, angular_rate, elapsed_time, zero fill
  input  logic [upi_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // pos_x, pos_y, heading, quat_z, quat_w
  output logic [upi_pkg::OUT_W-1:0] m_tdata
);
  import upi_pkg::*;

  upi_cmd_t cmd;

  upi_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd(cmd)
  );

  upi_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .in_data(s_tdata),
    .out_data(m_tdata)
  );

endmodule

/* bench/unicycle_pose_integrator_core_tb.sv */
// self-checking bench for unicycle_pose_integrator_core: a pose tracker class predicts
// every result from the accepted requests while both streams stall at random
// depends on upi_pkg and the rtl of unicycle_pose_integrator_core
module unicycle_pose_integrator_core_tb;
  import upi_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int TICK_COUNT  = 1850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  typedef enum int {
    MODE_MIXED,
    MODE_STRAIGHT,
    MODE_SPIN,
    MODE_CORNER
  } drive_mode_t;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] heading;
    logic [TRIG_W-1:0] qz;
    logic [TRIG_W-1:0] qw;
  } pose_t;

  class pose_tracker;
    logic [15:0]       sine_rom [TABLE_DEPTH];
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [HEAD_W-1:0] head;
    pose_t             expected_poses [$];
    int                mismatches;

    // (a * b) >> 61, unsigned
    function logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[124:61];
    endfunction

    // quarter-wave table rounded from an integer taylor series of sin
    function new();
      logic [63:0] den, q, r, xa, x2, term, sum, s46, val;
      den = 64'(2 * TABLE_DEPTH);
      q = PI_Q61 / den;
      r = PI_Q61 % den;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        xa = q * 64'(i) + (r * 64'(i)) / den;
        x2 = mul_q61(xa, xa);
        term = xa;
        sum = xa;
        for (int k = 1; k <= 20; k++) begin
          term = mul_q61(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        s46 = sum >> 15;
        val = (s46 * 64'd32767 + (64'd1 << 45)) >> 46;
        if (val > 64'd32767) val = 64'd32767;
        sine_rom[i] = val[15:0];
      end
      x_pos = '0;
      y_pos = '0;
      head = '0;
      mismatches = 0;
    endfunction

    function int sine_at(logic [15:0] a);
      int idx;
      int mag;
      idx = (int'(a[13:0]) * TABLE_DEPTH) >>> 14;
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      if (a[14]) mag = (idx == 0) ? int'(SINE_MAX) : int'(sine_rom[TABLE_DEPTH - idx]);
      else mag = int'(sine_rom[idx]);
      return a[15] ? -mag : mag;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    // move along the old heading, then turn
    function void note_tick(logic signed [15:0] speed, logic signed [15:0] rate,
                            logic [19:0] dt);
      longint travel, dx, dy, dh;
      logic [15:0] half;
      pose_t p;
      travel = (longint'(speed) * longint'(dt)) >>> 8;
      dx = (travel * longint'(sine_at(16'(head + QUARTER)))) >>> 15;
      dy = (travel * longint'(sine_at(head))) >>> 15;
      dh = (longint'(rate) * longint'(dt)) >>> 12;
      x_pos = x_pos + dx[31:0];
      y_pos = y_pos + dy[31:0];
      head = head + dh[15:0];
      half = head >> 1;
      p.x = x_pos;
      p.y = y_pos;
      p.heading = head;
      p.qz = 16'(sine_at(half));
      p.qw = 16'(sine_at(16'(half + QUARTER)));
      expected_poses.push_back(p);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pose(logic [OUT_W-1:0] data);
      pose_t p;
      if (expected_poses.size() == 0) begin
        $error("pose result with no request waiting: %0h", data);
        mismatches++;
        return;
      end
      p = expected_poses.pop_front();
      compare_field("pos_x", p.x, data[31:0]);
      compare_field("pos_y", p.y, data[63:32]);
      compare_field("heading", 32'(p.heading), 32'(data[79:64]));
      compare_field("quat_z", 32'(p.qz), 32'(data[95:80]));
      compare_field("quat_w", 32'(p.qw), 32'(data[111:96]));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  pose_tracker tracker;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          sender_calm = 0;
  bit          receiver_calm = 0;

  unicycle_pose_integrator_core #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("unicycle_pose_integrator_core: mismatch");
    $finish;
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_tick(logic signed [15:0] speed, logic signed [15:0] rate,
                           logic [19:0] dt);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, dt, rate, speed};
    do @(posedge clk); while (!s_tready);
    tracker.note_tick(speed, rate, dt);
  endtask

  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  // result side, with its own stalls and the long hold-off
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        repeat (hold_cycles) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
        hold_cycles = 0;
      end
      if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_pose(m_tdata);
    end
  end

  initial begin
    int          sent;
    int          seg_len;
    drive_mode_t mode;
    logic [15:0] speed, rate;
    logic [19:0] dt;
    bit          forward;
    tracker = new();
    s_tvalid = 1'b0;
    s_tdata = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero time, extremes, quarter turns through every quadrant, wraps
    send_tick(0, 0, 0);
    send_tick(32767, 0, 1048575);
    send_tick(-32768, 0, 1048575);
    send_tick(12345, -777, 0);
    send_tick(0, 0, 1048575);
    send_tick(256, 16384, 4096);
    send_tick(256, 16384, 4096);
    send_tick(-256, 16384, 4096);
    send_tick(32767, 16384, 4096);
    send_tick(-32768, -32768, 4096);
    send_tick(256, 32767, 1048575);
    send_tick(256, -32768, 1048575);
    send_tick(-1, -1, 1);
    send_tick(1, 1, 1);
    send_tick(32767, 1, 4096);
    send_tick(32767, -1, 4096);
    send_tick(-32768, 32767, 1048575);
    send_tick(32767, -32768, 1048575);
    send_tick(100, 8192, 1);
    send_tick(-100, 0, 0);
    sent = 20;

    while (sent < TICK_COUNT) begin
      seg_len = $urandom_range(10, 60);
      mode = drive_mode_t'($urandom_range(0, 3));
      sender_calm = ($urandom_range(0, 3) == 0);
      forward = $urandom_range(0, 1);
      for (int k = 0; k < seg_len && sent < TICK_COUNT; k++) begin
        case (mode)
          MODE_STRAIGHT: begin
            // long runs at full speed push the position past its wrap
            speed = forward ? 16'(32767 - $urandom_range(0, 255))
                            : 16'(32768 + $urandom_range(0, 255));
            rate = 16'd0;
            dt = 20'($urandom_range(20'h80000, 20'hFFFFF));
          end
          MODE_SPIN: begin
            speed = 16'($urandom);
            rate = 16'($urandom);
            dt = 20'($urandom_range(0, 8191));
          end
          MODE_CORNER: begin
            speed = corner16();
            rate = corner16();
            case ($urandom_range(0, 3))
              0: dt = 20'd0;
              1: dt = 20'hFFFFF;
              2: dt = 20'd1;
              default: dt = 20'd4096;
            endcase
          end
          default: begin
            speed = 16'($urandom);
            rate = 16'($urandom);
            dt = 20'($urandom_range(0, 20'hFFFFF));
          end
        endcase
        send_tick(speed, rate, dt);
        sent++;
        // output held off while requests keep coming
        if (sent == 600) hold_cycles = HOLD_LEN;
        // drain completely before going on
        if (sent == 1200) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          while (tracker.pending() != 0) @(posedge clk);
        end
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("unicycle_pose_integrator_core: match");
    end else begin
      $display("unicycle_pose_integrator_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/upi_pkg.sv
rtl/upi_sine_rom.sv
rtl/upi_datapath.sv
rtl/upi_ctrl.sv
rtl/unicycle_pose_integrator_core.sv
bench/unicycle_pose_integrator_core_tb.sv
